// ----- sv/spims_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spims_pkg;

   // widest word the shifter supports by default
   localparam int unsigned MAX_WORD_BITS_DEF = 32;

   // configuration port
   localparam int unsigned CSR_ADDR_WIDTH = 5;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   // register indexes, byte address is 4 * index
   typedef enum logic [2:0] {
      REG_ENABLE         = 3'd0,
      REG_CLOCK_POLARITY = 3'd1,
      REG_CLOCK_PHASE    = 3'd2,
      REG_LSB_FIRST      = 3'd3,
      REG_WORD_SIZE      = 3'd4,
      REG_CLOCK_DIVIDER  = 3'd5
   } reg_index_type;

   // word length codes, the two unused codes select the long word
   localparam logic [1:0] WORD_SIZE_8  = 2'd0;
   localparam logic [1:0] WORD_SIZE_16 = 2'd1;

   typedef struct packed {
      logic       enable;
      logic       clock_polarity;
      logic       clock_phase;
      logic       lsb_first;
      logic [1:0] word_size;
      logic [7:0] clock_divider;
   } cfg_type;

endpackage

`default_nettype wire

// ----- sv/spi_master_shift_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

// spi master shift engine, one req transfer per bus clock tick
// req channel: one item per tick with the start request (tuser), the word to
//    send and the sampled miso level (tdata); a start while busy or disabled
//    is dropped
// rsp channel: exactly one item per req item with sclk, mosi, busy, done and
//    the received word (nonzero only on the done tick)
// csr port: apb-style writes set enable, mode, bit order, word size and the
//    divider; each sclk half period lasts divider + 1 ticks
// latency: the rsp item for a req item is presented the cycle after its
//    transfer; throughput is one item per cycle while rsp_tready is high, set
//    by the single next-state stage between shifter state and rsp register
// stall: when rsp_tready is low the rsp register holds its item and
//    req_tready drops; the shifter advances only on accepted req items, so no
//    tick is lost or repeated
// reset: shifter idle, config cleared, rsp register empty; the block is
//    ready right after reset with no clearing pass
module spi_master_shift_engine #(
   parameter int unsigned MAX_WORD_BITS = spims_pkg::MAX_WORD_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // req: tdata [31:0] tx_word, [32] miso_level, [39:33] zero
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [39:0]                          req_tdata,
   // req: tuser [0] start_word
   input  wire logic                                 req_tuser,
   // rsp: tdata [0] sclk_level, [1] mosi_level, [2] busy_res, [3] done_res,
   //    [35:4] rx_word, [39:36] zero
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [39:0]                          rsp_tdata,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [spims_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [spims_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [spims_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                      csr_pready
);
   import spims_pkg::*;

   localparam int unsigned MW    = MAX_WORD_BITS;
   localparam int unsigned CNT_W = $clog2(MW + 1);

   // word lengths capped at the shifter width
   localparam logic [CNT_W-1:0] BITS_8  = CNT_W'(8);
   localparam logic [CNT_W-1:0] BITS_16 = CNT_W'((MW < 16) ? MW : 16);
   localparam logic [CNT_W-1:0] BITS_32 = CNT_W'(MW);
   // right shift that moves a full-width reversal down to the word length
   localparam logic [CNT_W-1:0] SHIFT_8  = CNT_W'(MW - 8);
   localparam logic [CNT_W-1:0] SHIFT_16 = CNT_W'(MW - ((MW < 16) ? MW : 16));
   localparam logic [CNT_W-1:0] SHIFT_32 = CNT_W'(0);
   localparam logic [MW-1:0]    MASK_8   = {MW{1'b1}} >> (MW - 8);
   localparam logic [MW-1:0]    MASK_16  = {MW{1'b1}} >> (MW - ((MW < 16) ? MW : 16));
   localparam logic [MW-1:0]    MASK_32  = {MW{1'b1}};

   function automatic logic [MW-1:0] reverse_bits(input logic [MW-1:0] v);
      logic [MW-1:0] r;
      for (int i = 0; i < MW; i++) begin
         r[i] = v[MW-1-i];
      end
      return r;
   endfunction

   cfg_type cfg;

   spims_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // req payload
   logic        start_word;
   logic [31:0] tx_word;
   logic        miso_level;

   assign start_word = req_tuser;
   assign tx_word    = req_tdata[31:0];
   assign miso_level = req_tdata[32];

   // shifter state
   logic [MW-1:0]    transmit_shift_ff, transmit_shift_in;
   logic [MW-1:0]    receive_shift_ff, receive_shift_in;
   logic [CNT_W-1:0] bits_remaining_ff, bits_remaining_in;
   logic [7:0]       divide_count_ff, divide_count_in;
   logic             second_half_ff, second_half_in;
   logic             active_ff, active_in;

   // rsp register
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic [39:0]      rsp_tdata_ff, rsp_tdata_in;

   logic             req_accept;

   // word length selection from the current setting
   logic [CNT_W-1:0] word_bits;
   logic [CNT_W-1:0] word_shift;
   logic [MW-1:0]    word_mask;

   logic [MW-1:0]    tx_masked;
   logic [MW-1:0]    rx_masked;
   logic [MW-1:0]    rx_ordered;
   logic             done_res;
   logic             sclk_level;
   logic             mosi_level;

   // a new item goes in when the rsp register is empty or being drained
   assign req_tready = ~rsp_tvalid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;

   always_comb begin
      case (cfg.word_size)
         WORD_SIZE_8: begin
            word_bits  = BITS_8;
            word_shift = SHIFT_8;
            word_mask  = MASK_8;
         end
         WORD_SIZE_16: begin
            word_bits  = BITS_16;
            word_shift = SHIFT_16;
            word_mask  = MASK_16;
         end
         default: begin
            word_bits  = BITS_32;
            word_shift = SHIFT_32;
            word_mask  = MASK_32;
         end
      endcase
   end

   assign tx_masked  = tx_word[MW-1:0] & word_mask;
   assign rx_masked  = receive_shift_ff & word_mask;
   // shifter collects msb first, flip for lsb-first order
   assign rx_ordered = cfg.lsb_first ? (reverse_bits(rx_masked) >> word_shift) : rx_masked;

   // next state for one tick
   always_comb begin
      transmit_shift_in = transmit_shift_ff;
      receive_shift_in  = receive_shift_ff;
      bits_remaining_in = bits_remaining_ff;
      divide_count_in   = divide_count_ff;
      second_half_in    = second_half_ff;
      active_in         = active_ff;
      done_res          = 1'b0;
      if (active_ff) begin
         if (!cfg.enable) begin
            // abort, no done pulse
            active_in         = 1'b0;
            second_half_in    = 1'b0;
            divide_count_in   = '0;
            bits_remaining_in = '0;
         end else if (divide_count_ff < cfg.clock_divider) begin
            divide_count_in = divide_count_ff + 8'd1;
         end else begin
            divide_count_in = '0;
            if (!second_half_ff) begin
               // sample miso at the end of the first half
               receive_shift_in = {receive_shift_ff[MW-2:0], miso_level};
               second_half_in   = 1'b1;
            end else begin
               second_half_in    = 1'b0;
               transmit_shift_in = transmit_shift_ff >> 1;
               bits_remaining_in = bits_remaining_ff - CNT_W'(1);
               if (bits_remaining_in == '0) begin
                  active_in = 1'b0;
                  done_res  = 1'b1;
               end
            end
         end
      end else if (start_word && cfg.enable) begin
         // mosi always takes bit 0, so msb-first words are loaded reversed
         transmit_shift_in = cfg.lsb_first ? tx_masked
                                           : (reverse_bits(tx_masked) >> word_shift);
         receive_shift_in  = '0;
         bits_remaining_in = word_bits;
         divide_count_in   = '0;
         second_half_in    = 1'b0;
         active_in         = 1'b1;
      end
   end

   // pin levels after this tick
   assign sclk_level = active_in ? (cfg.clock_polarity ^ cfg.clock_phase ^ second_half_in)
                                 : cfg.clock_polarity;
   assign mosi_level = active_in & transmit_shift_in[0];

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      if (req_accept) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {4'd0,
                          done_res ? 32'(rx_ordered) : 32'd0,
                          done_res,
                          active_in,
                          mosi_level,
                          sclk_level};
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         bits_remaining_ff <= '0;
         divide_count_ff   <= '0;
         second_half_ff    <= 1'b0;
         active_ff         <= 1'b0;
         rsp_tvalid_ff     <= 1'b0;
      end else begin
         if (req_accept) begin
            bits_remaining_ff <= bits_remaining_in;
            divide_count_ff   <= divide_count_in;
            second_half_ff    <= second_half_in;
            active_ff         <= active_in;
         end
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload, loaded at start before any use
   always_ff @(posedge clock) begin
      if (req_accept) begin
         transmit_shift_ff <= transmit_shift_in;
         receive_shift_ff  <= receive_shift_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire

// ----- sv/spims_csr.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spims_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [spims_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [spims_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [spims_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                      csr_pready,
   output spims_pkg::cfg_type                        cfg
);
   import spims_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_index;
   logic          write_strobe;

   assign csr_pready   = 1'b1;
   assign reg_index    = reg_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);
   assign write_strobe = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_strobe) begin
         case (reg_index)
            REG_ENABLE:         cfg_in.enable         = csr_pwdata[0];
            REG_CLOCK_POLARITY: cfg_in.clock_polarity = csr_pwdata[0];
            REG_CLOCK_PHASE:    cfg_in.clock_phase    = csr_pwdata[0];
            REG_LSB_FIRST:      cfg_in.lsb_first      = csr_pwdata[0];
            REG_WORD_SIZE:      cfg_in.word_size      = csr_pwdata[1:0];
            REG_CLOCK_DIVIDER:  cfg_in.clock_divider  = csr_pwdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_ENABLE:         csr_prdata = CSR_DATA_WIDTH'(cfg_ff.enable);
         REG_CLOCK_POLARITY: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.clock_polarity);
         REG_CLOCK_PHASE:    csr_prdata = CSR_DATA_WIDTH'(cfg_ff.clock_phase);
         REG_LSB_FIRST:      csr_prdata = CSR_DATA_WIDTH'(cfg_ff.lsb_first);
         REG_WORD_SIZE:      csr_prdata = CSR_DATA_WIDTH'(cfg_ff.word_size);
         REG_CLOCK_DIVIDER:  csr_prdata = CSR_DATA_WIDTH'(cfg_ff.clock_divider);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire
